// File: design/edid_bbp_pkg.sv
// Package for the EDID base block parser: record geometry, byte offsets,
// status codes, result and tracker status structs, header and capture lookups.
// No dependencies.
package edid_bbp_pkg;

   localparam int RECORD_BYTES = 128;
   localparam int COUNT_W      = 8;
   localparam int NUM_CAPTURES = 8;
   localparam int CAP_IDX_W    = 3;

   localparam logic [COUNT_W-1:0] LAST_POS    = COUNT_W'(RECORD_BYTES - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT  = COUNT_W'(RECORD_BYTES);
   localparam logic [COUNT_W-1:0] HEADER_LEN  = 8'd8;
   localparam logic [COUNT_W-1:0] POS_VERSION = 8'd18;
   localparam logic [COUNT_W-1:0] POS_PCLK_LO = 8'd54;
   localparam logic [COUNT_W-1:0] POS_PCLK_HI = 8'd55;

   localparam logic [7:0] VERSION_ONE = 8'h01;

   // capture slots, in store order
   localparam logic [CAP_IDX_W-1:0] CAP_VENDOR_HI  = 3'd0;
   localparam logic [CAP_IDX_W-1:0] CAP_VENDOR_LO  = 3'd1;
   localparam logic [CAP_IDX_W-1:0] CAP_PRODUCT_LO = 3'd2;
   localparam logic [CAP_IDX_W-1:0] CAP_PRODUCT_HI = 3'd3;
   localparam logic [CAP_IDX_W-1:0] CAP_HACT_LO    = 3'd4;
   localparam logic [CAP_IDX_W-1:0] CAP_HACT_HI    = 3'd5;
   localparam logic [CAP_IDX_W-1:0] CAP_VACT_LO    = 3'd6;
   localparam logic [CAP_IDX_W-1:0] CAP_VACT_HI    = 3'd7;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_TOO_SHORT   = 3'd1,
      ST_BAD_HEADER  = 3'd2,
      ST_BAD_VERSION = 3'd3,
      ST_CHECKSUM    = 3'd4,
      ST_NO_PIXCLK   = 3'd5
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [6:0]  vendor_first;
      logic [6:0]  vendor_second;
      logic [6:0]  vendor_third;
      logic [15:0] product_code;
      logic [11:0] active_width;
      logic [11:0] active_height;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] byte_count;
      logic               result_sent;
      logic               push;
   } trk_stat_type;

   typedef struct packed {
      logic                 hit;
      logic [CAP_IDX_W-1:0] idx;
   } cap_slot_type;

   function automatic logic [7:0] header_byte(input logic [2:0] pos);
      logic [7:0] val;
      case (pos)
         3'd0:    val = 8'h00;
         3'd7:    val = 8'h00;
         default: val = 8'hff;
      endcase
      return val;
   endfunction

   function automatic cap_slot_type capture_slot(input logic [COUNT_W-1:0] pos);
      cap_slot_type slot;
      slot.hit = 1'b1;
      case (pos)
         8'd8:    slot.idx = CAP_VENDOR_HI;
         8'd9:    slot.idx = CAP_VENDOR_LO;
         8'd10:   slot.idx = CAP_PRODUCT_LO;
         8'd11:   slot.idx = CAP_PRODUCT_HI;
         8'd56:   slot.idx = CAP_HACT_LO;
         8'd58:   slot.idx = CAP_HACT_HI;
         8'd59:   slot.idx = CAP_VACT_LO;
         8'd61:   slot.idx = CAP_VACT_HI;
         default: begin
            slot.hit = 1'b0;
            slot.idx = CAP_VENDOR_HI;
         end
      endcase
      return slot;
   endfunction

endpackage

// File: design/edid_bbp_track.sv
// Byte tracker: count, running sum, header/version/pixel clock flags and field
// captures; builds the result when the record completes or ends early.
// Depends on edid_bbp_pkg.
module edid_bbp_track (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic [7:0]                   byte_value,
   input  logic                         blob_end,
   output edid_bbp_pkg::rsp_type        rsp_data,
   output edid_bbp_pkg::trk_stat_type   stat
);

   logic [edid_bbp_pkg::COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]                       running_sum_ff, running_sum_in;
   logic                             header_ok_ff, header_ok_in;
   logic [7:0]                       version_byte_ff, version_byte_in;
   logic                             pixel_clock_seen_ff, pixel_clock_seen_in;
   logic                             result_sent_ff, result_sent_in;
   logic [7:0]                       captured_ff [edid_bbp_pkg::NUM_CAPTURES];

   logic                             passive;
   logic                             at_last;
   logic                             emit;
   logic [7:0]                       sum_next;
   edid_bbp_pkg::cap_slot_type       slot;
   edid_bbp_pkg::status_type         status;
   logic [15:0]                      mfg_word;

   assign passive  = result_sent_ff || (byte_count_ff >= edid_bbp_pkg::FULL_COUNT);
   assign at_last  = (byte_count_ff == edid_bbp_pkg::LAST_POS);
   assign emit     = take && !passive && (at_last || blob_end);
   assign sum_next = running_sum_ff + byte_value;
   assign slot     = edid_bbp_pkg::capture_slot(byte_count_ff);

   always_comb begin
      byte_count_in       = byte_count_ff;
      running_sum_in      = running_sum_ff;
      header_ok_in        = header_ok_ff;
      version_byte_in     = version_byte_ff;
      pixel_clock_seen_in = pixel_clock_seen_ff;
      result_sent_in      = result_sent_ff;
      if (take) begin
         if (!passive) begin
            byte_count_in  = byte_count_ff + 8'd1;
            running_sum_in = sum_next;
            if ((byte_count_ff < edid_bbp_pkg::HEADER_LEN) &&
                (byte_value != edid_bbp_pkg::header_byte(byte_count_ff[2:0]))) begin
               header_ok_in = 1'b0;
            end
            if (byte_count_ff == edid_bbp_pkg::POS_VERSION) begin
               version_byte_in = byte_value;
            end
            if (((byte_count_ff == edid_bbp_pkg::POS_PCLK_LO) ||
                 (byte_count_ff == edid_bbp_pkg::POS_PCLK_HI)) && (byte_value != 8'd0)) begin
               pixel_clock_seen_in = 1'b1;
            end
            if (at_last && !blob_end) begin
               result_sent_in = 1'b1;
            end
         end
         // end of blob: back to the idle state
         if (blob_end) begin
            byte_count_in       = '0;
            running_sum_in      = '0;
            header_ok_in        = 1'b1;
            version_byte_in     = '0;
            pixel_clock_seen_in = 1'b0;
            result_sent_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff       <= '0;
         running_sum_ff      <= '0;
         header_ok_ff        <= 1'b1;
         version_byte_ff     <= '0;
         pixel_clock_seen_ff <= 1'b0;
         result_sent_ff      <= 1'b0;
      end else begin
         byte_count_ff       <= byte_count_in;
         running_sum_ff      <= running_sum_in;
         header_ok_ff        <= header_ok_in;
         version_byte_ff     <= version_byte_in;
         pixel_clock_seen_ff <= pixel_clock_seen_in;
         result_sent_ff      <= result_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !passive && slot.hit) begin
         captured_ff[slot.idx] <= byte_value;
      end
   end

   // only the sum can change on the final byte; other checks sit in registers already
   always_comb begin
      if (!at_last) begin
         status = edid_bbp_pkg::ST_TOO_SHORT;
      end else if (!header_ok_ff) begin
         status = edid_bbp_pkg::ST_BAD_HEADER;
      end else if (version_byte_ff != edid_bbp_pkg::VERSION_ONE) begin
         status = edid_bbp_pkg::ST_BAD_VERSION;
      end else if (sum_next != 8'd0) begin
         status = edid_bbp_pkg::ST_CHECKSUM;
      end else if (!pixel_clock_seen_ff) begin
         status = edid_bbp_pkg::ST_NO_PIXCLK;
      end else begin
         status = edid_bbp_pkg::ST_OK;
      end
   end

   assign mfg_word = {captured_ff[edid_bbp_pkg::CAP_VENDOR_HI],
                      captured_ff[edid_bbp_pkg::CAP_VENDOR_LO]};

   always_comb begin
      rsp_data        = '0;
      rsp_data.status = status;
      if (status == edid_bbp_pkg::ST_OK) begin
         rsp_data.vendor_first  = {2'b10, mfg_word[14:10]};
         rsp_data.vendor_second = {2'b10, mfg_word[9:5]};
         rsp_data.vendor_third  = {2'b10, mfg_word[4:0]};
         rsp_data.product_code  = {captured_ff[edid_bbp_pkg::CAP_PRODUCT_HI],
                                   captured_ff[edid_bbp_pkg::CAP_PRODUCT_LO]};
         rsp_data.active_width  = {captured_ff[edid_bbp_pkg::CAP_HACT_HI][7:4],
                                   captured_ff[edid_bbp_pkg::CAP_HACT_LO]};
         rsp_data.active_height = {captured_ff[edid_bbp_pkg::CAP_VACT_HI][7:4],
                                   captured_ff[edid_bbp_pkg::CAP_VACT_LO]};
      end
   end

   assign stat.byte_count  = byte_count_ff;
   assign stat.result_sent = result_sent_ff;
   assign stat.push        = emit;

endmodule

// File: design/edid_bbp_outbuf.sv
// Result register with a skid entry behind it.
// Depends on edid_bbp_pkg.
module edid_bbp_outbuf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  edid_bbp_pkg::rsp_type  push_data,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output edid_bbp_pkg::rsp_type  rsp_data,
   output logic                   full
);

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   edid_bbp_pkg::rsp_type out_data_ff, out_data_in;
   edid_bbp_pkg::rsp_type skid_data_ff, skid_data_in;
   logic                  pop;

   assign pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            // drain skid first; no push can arrive while it is full
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign full      = skid_valid_ff;

endmodule

// File: design/edid_base_block_parser_top.sv
// EDID base block parser, top level. One request byte per cycle.
// A result is registered onto rsp_ from the request that ends the record, via the skid entry while rsp_ is held.
// Throughput: one byte per cycle; req_stall rises only while two results wait (skid full).
// Reset (synchronous) clears the byte count, sum, flags and result buffer valid bits;
// captured field bytes are not reset.
// Depends on edid_bbp_pkg, edid_bbp_track, edid_bbp_outbuf.
module edid_base_block_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_blob_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_vendor_first,
   output logic [6:0]  rsp_vendor_second,
   output logic [6:0]  rsp_vendor_third,
   output logic [15:0] rsp_product_code,
   output logic [11:0] rsp_active_width,
   output logic [11:0] rsp_active_height
);

   logic                       take;
   logic                       full;
   edid_bbp_pkg::rsp_type      push_data;
   edid_bbp_pkg::rsp_type      out_data;
   edid_bbp_pkg::trk_stat_type stat;

   assign req_stall = full;
   assign take      = req_valid && !full;

   edid_bbp_track u_track (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .byte_value (req_byte_value),
      .blob_end   (req_blob_end),
      .rsp_data   (push_data),
      .stat       (stat)
   );

   edid_bbp_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (stat.push),
      .push_data (push_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (out_data),
      .full      (full)
   );

   assign rsp_status        = out_data.status;
   assign rsp_vendor_first  = out_data.vendor_first;
   assign rsp_vendor_second = out_data.vendor_second;
   assign rsp_vendor_third  = out_data.vendor_third;
   assign rsp_product_code  = out_data.product_code;
   assign rsp_active_width  = out_data.active_width;
   assign rsp_active_height = out_data.active_height;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.byte_count <= edid_bbp_pkg::FULL_COUNT)
      else $error("byte count ran past the record length");

   a_sent_full: assert property (@(posedge clock) disable iff (reset)
      stat.result_sent |-> (stat.byte_count == edid_bbp_pkg::FULL_COUNT))
      else $error("result marked sent before the record was complete");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      full |-> rsp_valid)
      else $error("skid entry held while the result register is empty");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      stat.push |=> rsp_valid)
      else $error("result pushed but no response offered");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for edid_base_block_parser_top: a queue-fed request driver, a result
// monitor and a byte-level tracker that predicts every result. Depends on edid_bbp_pkg.
module tb_top;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } blob_byte_type;

   localparam int KIND_GOOD        = 0;
   localparam int KIND_BAD_HEADER  = 1;
   localparam int KIND_BAD_VERSION = 2;
   localparam int KIND_BAD_SUM     = 3;
   localparam int KIND_NO_PIXCLK   = 4;

   localparam int PHASE_LEN = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_value = 8'h00;
   logic        req_blob_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [6:0]  rsp_vendor_first;
   logic [6:0]  rsp_vendor_second;
   logic [6:0]  rsp_vendor_third;
   logic [15:0] rsp_product_code;
   logic [11:0] rsp_active_width;
   logic [11:0] rsp_active_height;

   blob_byte_type         pending_bytes[$];
   edid_bbp_pkg::rsp_type expected_rsps[$];
   blob_byte_type         next_byte;
   edid_bbp_pkg::rsp_type want;
   int         taken_cnt = 0;
   int         blob_cnt = 0;
   logic [1:0] idle_phase = 2'd0;
   bit         failed = 1'b0;

   // parser state as the tracker sees it
   logic [7:0] trk_count;
   logic [7:0] trk_sum;
   logic       trk_hdr_ok;
   logic [7:0] trk_version;
   logic       trk_pclk;
   logic [7:0] trk_caps [8];
   logic       trk_sent;

   edid_base_block_parser_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_byte_value    (req_byte_value),
      .req_blob_end      (req_blob_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_vendor_first  (rsp_vendor_first),
      .rsp_vendor_second (rsp_vendor_second),
      .rsp_vendor_third  (rsp_vendor_third),
      .rsp_product_code  (rsp_product_code),
      .rsp_active_width  (rsp_active_width),
      .rsp_active_height (rsp_active_height)
   );

   always #5 clock = ~clock;

   function automatic int send_idle_pct(input logic [1:0] ph);
      case (ph)
         2'd1:    return 56;
         2'd3:    return 26;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct(input logic [1:0] ph);
      case (ph)
         2'd2:    return 56;
         2'd3:    return 26;
         default: return 0;
      endcase
   endfunction

   function automatic logic [7:0] sync_pattern(input int pos);
      return (pos == 0 || pos == 7) ? 8'h00 : 8'hff;
   endfunction

   task automatic clear_tracker();
      trk_count   = '0;
      trk_sum     = '0;
      trk_hdr_ok  = 1'b1;
      trk_version = '0;
      trk_pclk    = 1'b0;
      trk_sent    = 1'b0;
      foreach (trk_caps[k]) trk_caps[k] = '0;
   endtask

   function automatic edid_bbp_pkg::rsp_type blob_result();
      edid_bbp_pkg::rsp_type r;
      logic [15:0]           vc;
      r = '0;
      if (trk_count < edid_bbp_pkg::FULL_COUNT) r.status = edid_bbp_pkg::ST_TOO_SHORT;
      else if (!trk_hdr_ok) r.status = edid_bbp_pkg::ST_BAD_HEADER;
      else if (trk_version != edid_bbp_pkg::VERSION_ONE) r.status = edid_bbp_pkg::ST_BAD_VERSION;
      else if (trk_sum != 8'h00) r.status = edid_bbp_pkg::ST_CHECKSUM;
      else if (!trk_pclk) r.status = edid_bbp_pkg::ST_NO_PIXCLK;
      else r.status = edid_bbp_pkg::ST_OK;
      if (r.status == edid_bbp_pkg::ST_OK) begin
         vc = {trk_caps[0], trk_caps[1]};
         r.vendor_first  = {2'b10, vc[14:10]};
         r.vendor_second = {2'b10, vc[9:5]};
         r.vendor_third  = {2'b10, vc[4:0]};
         r.product_code  = {trk_caps[3], trk_caps[2]};
         r.active_width  = {trk_caps[5][7:4], trk_caps[4]};
         r.active_height = {trk_caps[7][7:4], trk_caps[6]};
      end
      return r;
   endfunction

   task automatic track_request(input logic [7:0] b, input logic last);
      int pos;
      if (trk_sent || trk_count >= edid_bbp_pkg::FULL_COUNT) begin
         // past the record: drop until the blob ends
         if (last) clear_tracker();
      end else begin
         pos = trk_count;
         trk_sum = trk_sum + b;
         if (pos < 8 && b != sync_pattern(pos)) trk_hdr_ok = 1'b0;
         if (pos == edid_bbp_pkg::POS_VERSION) trk_version = b;
         if ((pos == edid_bbp_pkg::POS_PCLK_LO || pos == edid_bbp_pkg::POS_PCLK_HI) &&
             b != 8'h00) trk_pclk = 1'b1;
         case (pos)
            8:  trk_caps[0] = b;
            9:  trk_caps[1] = b;
            10: trk_caps[2] = b;
            11: trk_caps[3] = b;
            56: trk_caps[4] = b;
            58: trk_caps[5] = b;
            59: trk_caps[6] = b;
            61: trk_caps[7] = b;
            default: ;
         endcase
         trk_count = trk_count + 8'd1;
         if (trk_count >= edid_bbp_pkg::FULL_COUNT) begin
            expected_rsps.push_back(blob_result());
            if (last) clear_tracker();
            else trk_sent = 1'b1;
         end else if (last) begin
            expected_rsps.push_back(blob_result());
            clear_tracker();
         end
      end
   endtask

   task automatic push_byte(input logic [7:0] v, input logic last);
      blob_byte_type it;
      it.value = v;
      it.last  = last;
      pending_bytes.push_back(it);
   endtask

   // queue the first cut bytes of a base block; a full block ends at its last byte
   // when trail is 0, else trail extra bytes follow with the end mark on the final one
   task automatic add_blob(input int kind, input int cut, input int trail);
      logic [7:0] rec [128];
      logic [7:0] acc;
      int         sel;
      int         k;
      for (k = 0; k < 128; k++) rec[k] = 8'($urandom_range(255));
      for (k = 0; k < 8; k++) rec[k] = sync_pattern(k);
      rec[18] = edid_bbp_pkg::VERSION_ONE;
      sel = $urandom_range(7);
      if (sel == 0 || sel == 1) begin
         // push the captured fields to their extremes
         rec[8] = {8{sel[0]}};  rec[9] = {8{sel[0]}};
         rec[10] = {8{sel[0]}}; rec[11] = {8{sel[0]}};
         rec[56] = {8{sel[0]}}; rec[58] = {8{sel[0]}};
         rec[59] = {8{sel[0]}}; rec[61] = {8{sel[0]}};
      end
      sel = $urandom_range(2);
      rec[54] = (sel != 1) ? 8'($urandom_range(255, 1)) : 8'h00;
      rec[55] = (sel != 0) ? 8'($urandom_range(255, 1)) : 8'h00;
      case (kind)
         KIND_BAD_HEADER: begin
            sel = $urandom_range(7);
            rec[sel] = rec[sel] ^ 8'($urandom_range(255, 1));
         end
         KIND_BAD_VERSION: rec[18] = edid_bbp_pkg::VERSION_ONE ^ 8'($urandom_range(255, 1));
         KIND_NO_PIXCLK: begin
            rec[54] = 8'h00;
            rec[55] = 8'h00;
         end
         default: ;
      endcase
      acc = 8'h00;
      for (k = 0; k < 127; k++) acc = acc + rec[k];
      rec[127] = 8'h00 - acc;
      if (kind == KIND_BAD_SUM) rec[127] = rec[127] + 8'($urandom_range(255, 1));
      for (k = 0; k < cut; k++)
         push_byte(rec[k], (cut < 128) ? (k == cut - 1) : (trail == 0 && k == 127));
      if (cut == 128)
         for (k = 0; k < trail; k++) push_byte(8'($urandom_range(255)), k == trail - 1);
      blob_cnt++;
   endtask

   task automatic add_noise();
      int n;
      int k;
      n = $urandom_range(6, 1);
      for (k = 0; k < n; k++)
         push_byte(8'($urandom_range(255)), (k == n - 1) ? 1'b1 : 1'($urandom_range(1)));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid      <= 1'b0;
         req_byte_value <= 8'h00;
         req_blob_end   <= 1'b0;
         idle_phase     <= 2'd0;
      end else begin
         if (req_valid && !req_stall) begin
            track_request(req_byte_value, req_blob_end);
            taken_cnt++;
            idle_phase <= 2'((taken_cnt / PHASE_LEN) % 4);
         end
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct(idle_phase))
            begin
               next_byte = pending_bytes.pop_front();
               req_valid      <= 1'b1;
               req_byte_value <= next_byte.value;
               req_blob_end   <= next_byte.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result, status %0d", rsp_status);
               failed = 1'b1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  failed = 1'b1;
               end
               if (rsp_vendor_first !== want.vendor_first) begin
                  $error("vendor_first: expected %0d, got %0d",
                         want.vendor_first, rsp_vendor_first);
                  failed = 1'b1;
               end
               if (rsp_vendor_second !== want.vendor_second) begin
                  $error("vendor_second: expected %0d, got %0d",
                         want.vendor_second, rsp_vendor_second);
                  failed = 1'b1;
               end
               if (rsp_vendor_third !== want.vendor_third) begin
                  $error("vendor_third: expected %0d, got %0d",
                         want.vendor_third, rsp_vendor_third);
                  failed = 1'b1;
               end
               if (rsp_product_code !== want.product_code) begin
                  $error("product_code: expected %0d, got %0d",
                         want.product_code, rsp_product_code);
                  failed = 1'b1;
               end
               if (rsp_active_width !== want.active_width) begin
                  $error("active_width: expected %0d, got %0d",
                         want.active_width, rsp_active_width);
                  failed = 1'b1;
               end
               if (rsp_active_height !== want.active_height) begin
                  $error("active_height: expected %0d, got %0d",
                         want.active_height, rsp_active_height);
                  failed = 1'b1;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct(idle_phase));
      end
   end

   initial begin
      int roll;
      int kind;
      clear_tracker();
      // short blobs: single bytes at both extremes, a bare header, a truncated record
      push_byte(8'h00, 1'b1);
      push_byte(8'hff, 1'b1);
      add_blob(KIND_GOOD, 8, 0);
      add_blob(KIND_BAD_HEADER, 3, 0);
      add_blob(KIND_GOOD, 1, 0);
      add_noise();
      // full blocks of every kind, two with bytes past the end, then an end mark one byte early
      add_blob(KIND_GOOD, 128, 0);
      add_blob(KIND_GOOD, 128, 3);
      add_blob(KIND_BAD_HEADER, 128, 0);
      add_blob(KIND_BAD_VERSION, 128, 0);
      add_blob(KIND_BAD_SUM, 128, 1);
      add_blob(KIND_NO_PIXCLK, 128, 0);
      add_blob(KIND_GOOD, 127, 0);
      while (pending_bytes.size() < 1700 || blob_cnt < 60) begin
         roll = $urandom_range(99);
         kind = $urandom_range(9);
         if (kind > KIND_NO_PIXCLK + 3) kind = KIND_GOOD;
         else if (kind > KIND_NO_PIXCLK) kind = KIND_GOOD;
         if (roll < 10)
            add_noise();
         else if (roll < 45)
            add_blob(kind, ($urandom_range(3) == 0) ? $urandom_range(127, 1)
                                                    : $urandom_range(20, 1), 0);
         else
            add_blob(kind, 128, ($urandom_range(1) == 0) ? 0 : $urandom_range(4, 1));
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed && expected_rsps.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
